// File: sv/pbrs_pkg.sv
// Shared types, constants and width helpers for the bitmap priority scheduler.
`timescale 1ns / 1ps
`default_nettype none

package pbrs_pkg;

    localparam int PRIORITY_LEVELS = 32;
    localparam int THREAD_SLOTS    = 32;

    localparam int LVL_W = (PRIORITY_LEVELS > 1) ? $clog2(PRIORITY_LEVELS) : 1;
    localparam int THR_W = (THREAD_SLOTS > 1) ? $clog2(THREAD_SLOTS) : 1;

    typedef enum logic [1:0] {
        REQ_INSERT   = 2'd0,
        REQ_REMOVE   = 2'd1,
        REQ_SCHEDULE = 2'd2,
        REQ_START    = 2'd3
    } t_req_type;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_EMPTY  = 2'd1,
        ST_DOUBLE = 2'd2,
        ST_ABSENT = 2'd3
    } t_status;

    typedef struct packed {
        t_req_type  req_type;
        logic [4:0] thread_id;
        logic [4:0] priority_req;
    } t_req;

    typedef struct packed {
        t_status    status;
        logic       switched;
        logic       from_valid;
        logic [4:0] prev_thread;
        logic [4:0] next_thread;
        logic [4:0] to_priority;
    } t_res;

    // Five-bit field to internal thread index (zero-extend or truncate).
    function automatic logic [THR_W-1:0] thr_of(input logic [4:0] id);
        logic [THR_W+4:0] w;
        w = {{THR_W{1'b0}}, id};
        return w[THR_W-1:0];
    endfunction

    // Five-bit field to internal level index.
    function automatic logic [LVL_W-1:0] lvl_of(input logic [4:0] pr);
        logic [LVL_W+4:0] w;
        w = {{LVL_W{1'b0}}, pr};
        return w[LVL_W-1:0];
    endfunction

    // Internal thread index back to the five-bit result field.
    function automatic logic [4:0] thr_out(input logic [THR_W-1:0] t);
        logic [THR_W+4:0] w;
        w = {5'b0, t};
        return w[4:0];
    endfunction

    // Internal level index back to the five-bit result field.
    function automatic logic [4:0] lvl_out(input logic [LVL_W-1:0] l);
        logic [LVL_W+4:0] w;
        w = {5'b0, l};
        return w[4:0];
    endfunction

endpackage

`default_nettype wire

// File: sv/pbrs_find.sv
// Lowest-set-bit search over the ready bitmap.
`timescale 1ns / 1ps
`default_nettype none

module pbrs_find (
    input  wire logic [pbrs_pkg::PRIORITY_LEVELS-1:0] i_mask,
    output logic                                      o_any,
    output logic [pbrs_pkg::LVL_W-1:0]                o_level
);
    import pbrs_pkg::*;

    // Scanning downwards lets the most urgent set level win.
    always_comb begin
        o_level = LVL_W'(PRIORITY_LEVELS - 1);
        for (int i = PRIORITY_LEVELS - 1; i >= 0; i--) begin
            if (i_mask[i]) begin
                o_level = LVL_W'(i);
            end
        end
    end

    assign o_any = |i_mask;

endmodule

`default_nettype wire

// File: sv/pbrs_queue.sv
// Ready bitmap, per-level linked lists and running-thread state with request logic.
`timescale 1ns / 1ps
`default_nettype none

module pbrs_queue (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_fire,
    input  wire pbrs_pkg::t_req i_req,
    output pbrs_pkg::t_res      o_res
);
    import pbrs_pkg::*;

    // State.
    logic [PRIORITY_LEVELS-1:0] r_mask;
    logic [THREAD_SLOTS-1:0]    r_queued;
    logic [THR_W-1:0]           r_head  [PRIORITY_LEVELS];
    logic [THR_W-1:0]           r_tail  [PRIORITY_LEVELS];
    logic [THR_W-1:0]           r_next  [THREAD_SLOTS];
    logic [THR_W-1:0]           r_prev  [THREAD_SLOTS];
    logic [LVL_W-1:0]           r_qlevel[THREAD_SLOTS];
    logic [THR_W-1:0]           r_run_thread;
    logic                       r_run_valid;

    // Decoded request.
    logic [THR_W-1:0] w_t;
    logic [LVL_W-1:0] w_prs;
    logic             w_thr_ok;
    logic             w_any;
    logic [LVL_W-1:0] w_find_lvl;
    logic [LVL_W-1:0] w_rd_lvl;
    logic [THR_W-1:0] w_head_rd;
    logic [THR_W-1:0] w_tail_rd;

    // Write controls.
    logic                       w_head_we, w_tail_we, w_next_we, w_prev_we;
    logic [LVL_W-1:0]           w_head_addr, w_tail_addr;
    logic [THR_W-1:0]           w_head_wd, w_tail_wd;
    logic [THR_W-1:0]           w_next_addr, w_next_wd, w_prev_addr, w_prev_wd;
    logic                       w_q_set, w_q_clr;
    logic                       w_run_we;
    logic [PRIORITY_LEVELS-1:0] w_mask_set, w_mask_clr;
    logic [PRIORITY_LEVELS-1:0] n_mask;
    logic [THREAD_SLOTS-1:0]    n_queued;
    logic                       w_at_head, w_at_tail, w_change;

    assign w_t      = thr_of(i_req.thread_id);
    assign w_thr_ok = 32'(i_req.thread_id) < 32'(THREAD_SLOTS);
    assign w_prs    = (32'(i_req.priority_req) >= 32'(PRIORITY_LEVELS))
                    ? LVL_W'(PRIORITY_LEVELS - 1) : lvl_of(i_req.priority_req);

    pbrs_find u_find (
        .i_mask  (r_mask),
        .o_any   (w_any),
        .o_level (w_find_lvl)
    );

    // One level read port serves every request type.
    always_comb begin
        case (i_req.req_type)
            REQ_INSERT: w_rd_lvl = w_prs;
            REQ_REMOVE: w_rd_lvl = r_qlevel[w_t];
            default:    w_rd_lvl = w_find_lvl;
        endcase
    end

    assign w_head_rd = r_head[w_rd_lvl];
    assign w_tail_rd = r_tail[w_rd_lvl];
    assign w_at_head = (w_head_rd == w_t);
    assign w_at_tail = (w_tail_rd == w_t);
    assign w_change  = !r_run_valid || (r_run_thread != w_head_rd);

    always_comb begin
        o_res       = '0;
        o_res.status = ST_OK;
        w_head_we   = 1'b0;
        w_tail_we   = 1'b0;
        w_next_we   = 1'b0;
        w_prev_we   = 1'b0;
        w_head_addr = w_rd_lvl;
        w_tail_addr = w_rd_lvl;
        w_head_wd   = w_t;
        w_tail_wd   = w_t;
        w_next_addr = w_tail_rd;
        w_next_wd   = w_t;
        w_prev_addr = w_t;
        w_prev_wd   = w_tail_rd;
        w_q_set     = 1'b0;
        w_q_clr     = 1'b0;
        w_run_we    = 1'b0;
        w_mask_set  = '0;
        w_mask_clr  = '0;
        case (i_req.req_type)
            REQ_INSERT: begin
                if (!w_thr_ok) begin
                    o_res.status = ST_ABSENT;
                end else if (r_queued[w_t]) begin
                    o_res.status = ST_DOUBLE;
                end else begin
                    // Append at the tail; an empty level gets a new head.
                    if (r_mask[w_rd_lvl]) begin
                        w_next_we = 1'b1;
                        w_prev_we = 1'b1;
                    end else begin
                        w_head_we = 1'b1;
                    end
                    w_tail_we  = 1'b1;
                    w_q_set    = 1'b1;
                    w_mask_set = PRIORITY_LEVELS'(1) << w_rd_lvl;
                end
            end
            REQ_REMOVE: begin
                if (!w_thr_ok) begin
                    o_res.status = ST_ABSENT;
                end else if (!r_queued[w_t]) begin
                    o_res.status = ST_ABSENT;
                end else begin
                    w_q_clr = 1'b1;
                    if (w_at_head && w_at_tail) begin
                        w_mask_clr = PRIORITY_LEVELS'(1) << w_rd_lvl;
                    end else if (w_at_head) begin
                        w_head_we = 1'b1;
                        w_head_wd = r_next[w_t];
                    end else if (w_at_tail) begin
                        w_tail_we = 1'b1;
                        w_tail_wd = r_prev[w_t];
                    end else begin
                        // Thread in the middle: splice its neighbours together.
                        w_next_we   = 1'b1;
                        w_next_addr = r_prev[w_t];
                        w_next_wd   = r_next[w_t];
                        w_prev_we   = 1'b1;
                        w_prev_addr = r_next[w_t];
                        w_prev_wd   = r_prev[w_t];
                    end
                end
            end
            REQ_SCHEDULE, REQ_START: begin
                if (!w_any) begin
                    o_res.status = ST_EMPTY;
                end else begin
                    o_res.switched    = w_change;
                    o_res.from_valid  = r_run_valid;
                    o_res.prev_thread = thr_out(r_run_thread);
                    o_res.next_thread = thr_out(w_head_rd);
                    o_res.to_priority = lvl_out(w_find_lvl);
                    w_run_we = w_change || (i_req.req_type == REQ_START);
                end
            end
            default: begin
                o_res.status = ST_OK;
            end
        endcase
    end

    assign n_mask = (r_mask | w_mask_set) & ~w_mask_clr;

    always_comb begin
        n_queued = r_queued;
        if (w_q_set) begin
            n_queued[w_t] = 1'b1;
        end
        if (w_q_clr) begin
            n_queued[w_t] = 1'b0;
        end
    end

    // Control state with reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask       <= '0;
            r_queued     <= '0;
            r_run_valid  <= 1'b0;
            r_run_thread <= '0;
        end else if (i_fire) begin
            r_mask   <= n_mask;
            r_queued <= n_queued;
            if (w_run_we) begin
                r_run_valid  <= 1'b1;
                r_run_thread <= w_head_rd;
            end
        end
    end

    // Link stores: no reset, every read is guarded by the bitmap or queued flags.
    always_ff @(posedge i_clk) begin
        if (i_fire) begin
            if (w_head_we) begin
                r_head[w_head_addr] <= w_head_wd;
            end
            if (w_tail_we) begin
                r_tail[w_tail_addr] <= w_tail_wd;
            end
            if (w_next_we) begin
                r_next[w_next_addr] <= w_next_wd;
            end
            if (w_prev_we) begin
                r_prev[w_prev_addr] <= w_prev_wd;
            end
            if (w_q_set) begin
                r_qlevel[w_t] <= w_rd_lvl;
            end
        end
    end

    // A queued thread always sits on a level whose bitmap bit is set.
    a_queued_level_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_thr_ok && r_queued[w_t]) |-> r_mask[r_qlevel[w_t]])
        else $error("queued thread on a level with a clear ready bit");

    // An empty answer only comes from an empty bitmap.
    a_empty_means_no_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && (o_res.status == ST_EMPTY)) |-> (r_mask == '0))
        else $error("empty status with ready levels present");

    // A successful remove leaves the thread unqueued.
    a_remove_clears_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && (i_req.req_type == REQ_REMOVE) && (o_res.status == ST_OK))
        |=> !r_queued[$past(w_t)])
        else $error("removed thread still flagged as queued");

endmodule

`default_nettype wire

// File: sv/priority_bitmap_ready_scheduler.sv
// Top level of the bitmap priority scheduler: input register, request logic, result register.
//
//  Channel   Direction  Handshake                     Payload
//  request   in         i_in_valid / o_in_ready       i_in_data  (pbrs_pkg::t_req)
//  result    out        o_out_valid / i_out_ready     o_out_data (pbrs_pkg::t_res)
//
// A request transfer loads the input register; when the held request fires, the queue
// update logic writes the result register, which raises o_out_valid.
// One request can be taken every cycle while the result side does not stall, because
// the whole list update for a request (one level read, the link reads of one thread,
// one write per store) completes in a single pass.
// Reset clears the ready bitmap, the queued flags and the running thread; the link
// stores need no clearing, so requests are accepted straight after reset.
// While a result waits untaken, the request held in the input register stalls, and
// the input side takes no further transfer until the result register frees up.
`timescale 1ns / 1ps
`default_nettype none

module priority_bitmap_ready_scheduler (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    output logic                o_in_ready,
    input  wire pbrs_pkg::t_req i_in_data,
    output logic                o_out_valid,
    input  wire logic           i_out_ready,
    output pbrs_pkg::t_res      o_out_data
);
    import pbrs_pkg::*;

    t_req r_in;
    logic r_in_valid;
    t_res r_out;
    logic r_out_valid;
    t_res w_res;
    logic w_fire;

    // The held request is processed when the result register is free or being emptied.
    assign w_fire     = r_in_valid && (!r_out_valid || i_out_ready);
    // The input register takes a new transfer when empty or when its request moves on.
    assign o_in_ready = !r_in_valid || w_fire;

    pbrs_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (w_fire),
        .i_req   (r_in),
        .o_res   (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (w_fire) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in <= i_in_data;
        end
        if (w_fire) begin
            r_out <= w_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // Every processed request lands in the result register.
    a_fire_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fire |=> o_out_valid)
        else $error("processed request produced no result");

    // A switch is only ever reported together with an ok status.
    a_switch_only_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.switched) |-> (o_out_data.status == ST_OK))
        else $error("switch reported on a failed request");

    // A stalled result stays offered with its payload unchanged.
    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_out_data)))
        else $error("stalled result dropped or changed");

endmodule

`default_nettype wire

// File: verif/priority_bitmap_ready_scheduler_test.sv
// Self-checking testbench for the bitmap priority ready-queue scheduler.
`timescale 1ns / 1ps
`default_nettype none

module priority_bitmap_ready_scheduler_test;

    import pbrs_pkg::*;

    // Random requests after the directed opening; the final stretch runs with no idling.
    localparam int RAND_ITEMS = 1500;
    localparam int QUIET_TAIL = 200;

    // A request waiting to be offered, marked when it belongs to the idle-free tail.
    typedef struct {
        t_req rq;
        bit   quiet;
    } t_pend;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    logic req_valid = 1'b0;
    t_req req_data  = '0;
    logic in_ready;
    logic res_valid;
    logic res_ready = 1'b0;
    t_res res_data;

    always #10 i_clk = ~i_clk;

    priority_bitmap_ready_scheduler uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (req_valid),
        .o_in_ready (in_ready),
        .i_in_data  (req_data),
        .o_out_valid(res_valid),
        .i_out_ready(res_ready),
        .o_out_data (res_data)
    );

    // Requests still to be offered, and the results owed for requests already taken.
    t_pend req_backlog[$];
    t_res  owed_results[$];

    // Shadow of the scheduler: ready bitmap, per-level FIFO ends, doubly linked thread
    // lists, per-thread queued flag and level, and the running thread.
    logic [PRIORITY_LEVELS-1:0] ready_bits;
    logic [4:0] lvl_head [PRIORITY_LEVELS];
    logic [4:0] lvl_tail [PRIORITY_LEVELS];
    logic [4:0] link_next [THREAD_SLOTS];
    logic [4:0] link_prev [THREAD_SLOTS];
    bit         is_queued [THREAD_SLOTS];
    logic [4:0] queued_lvl [THREAD_SLOTS];
    logic [4:0] run_thr;
    bit         run_valid;
    logic [4:0] run_lvl;

    // Which threads the stimulus believes are queued, so that it can form sensible removes.
    bit gen_queued [THREAD_SLOTS];

    int  mismatches   = 0;
    int  op_count [4] = '{default: 0};
    int  switch_count = 0;
    int  empty_count  = 0;
    int  send_gap     = 0;
    int  take_hold    = 0;
    bit  quiet_phase  = 1'b0;

    // Applies one request to the shadow state and returns the result the block owes for it.
    function automatic t_res apply_request(input t_req rq);
        t_res       r;
        logic [4:0] thr;
        logic [4:0] lvl;
        logic [4:0] lv;
        logic [4:0] head_thr;
        int         sel;
        bit         at_head;
        bit         at_tail;
        r   = '0;
        r.status = ST_OK;
        thr = rq.thread_id;
        // Levels beyond the last one fold onto the least urgent level.
        lvl = (int'(rq.priority_req) >= PRIORITY_LEVELS) ? 5'(PRIORITY_LEVELS - 1)
                                                          : rq.priority_req;
        case (rq.req_type)
            REQ_INSERT: begin
                if (int'(thr) >= THREAD_SLOTS) begin
                    r.status = ST_ABSENT;
                end else if (is_queued[thr]) begin
                    r.status = ST_DOUBLE;
                end else begin
                    // Append at the tail; an empty level takes the thread as its head.
                    if (ready_bits[lvl]) begin
                        link_next[lvl_tail[lvl]] = thr;
                        link_prev[thr] = lvl_tail[lvl];
                    end else begin
                        lvl_head[lvl] = thr;
                    end
                    lvl_tail[lvl]   = thr;
                    is_queued[thr]  = 1'b1;
                    queued_lvl[thr] = lvl;
                    ready_bits[lvl] = 1'b1;
                end
            end
            REQ_REMOVE: begin
                if (int'(thr) >= THREAD_SLOTS || !is_queued[thr]) begin
                    r.status = ST_ABSENT;
                end else begin
                    lv      = queued_lvl[thr];
                    at_head = (lvl_head[lv] == thr);
                    at_tail = (lvl_tail[lv] == thr);
                    if (at_head && at_tail) begin
                        ready_bits[lv] = 1'b0;
                    end else if (at_head) begin
                        lvl_head[lv] = link_next[thr];
                    end else if (at_tail) begin
                        lvl_tail[lv] = link_prev[thr];
                    end else begin
                        link_next[link_prev[thr]] = link_next[thr];
                        link_prev[link_next[thr]] = link_prev[thr];
                    end
                    is_queued[thr] = 1'b0;
                end
            end
            default: begin
                if (ready_bits == '0) begin
                    r.status = ST_EMPTY;
                end else begin
                    // The most urgent ready level is the lowest set bit.
                    sel = PRIORITY_LEVELS - 1;
                    for (int l = PRIORITY_LEVELS - 1; l >= 0; l--) begin
                        if (ready_bits[l]) sel = l;
                    end
                    head_thr      = lvl_head[sel];
                    r.from_valid  = run_valid;
                    r.prev_thread = run_thr;
                    r.next_thread = head_thr;
                    r.to_priority = 5'(sel);
                    r.switched    = !run_valid || (run_thr != head_thr);
                    // Start reloads the running thread even when it does not change.
                    if (r.switched || rq.req_type == REQ_START) begin
                        run_thr   = head_thr;
                        run_valid = 1'b1;
                        run_lvl   = 5'(sel);
                    end
                end
            end
        endcase
        return r;
    endfunction

    // Adds a request to the backlog and keeps the stimulus view of the queued threads.
    task automatic queue_request(input t_req_type op, input int thr, input int pr,
                                 input bit quiet);
        t_pend p;
        p.rq.req_type     = op;
        p.rq.thread_id    = thr[4:0];
        p.rq.priority_req = pr[4:0];
        p.quiet           = quiet;
        if (op == REQ_INSERT) gen_queued[thr[4:0]] = 1'b1;
        if (op == REQ_REMOVE) gen_queued[thr[4:0]] = 1'b0;
        req_backlog.push_back(p);
    endtask

    // Picks a thread that is queued, or one that is not, falling back to any thread.
    function automatic int pick_thread(input bit want_queued);
        int ids[$];
        for (int t = 0; t < THREAD_SLOTS; t++) begin
            if (gen_queued[t] == want_queued) ids.push_back(t);
        end
        if (ids.size() == 0) return $urandom_range(0, THREAD_SLOTS - 1);
        return ids[$urandom_range(0, ids.size() - 1)];
    endfunction

    // Holds the sender back until every request has been taken and every result returned.
    // Sampling on the falling edge keeps clear of the clocked processes.
    task automatic settle();
        while (req_backlog.size() != 0 || req_valid || owed_results.size() != 0) begin
            @(negedge i_clk);
        end
    endtask

    // Request driver. A transfer at this edge is predicted at once; then the valid is
    // either kept for the next backlog entry or dropped for an idle burst. The valid gets
    // exactly one nonblocking update per edge.
    always @(posedge i_clk) begin : drive_requests
        t_pend nxt_item;
        t_res  exp_res;
        logic  v;
        v = req_valid;
        if (i_rst_n) begin
            if (req_valid && in_ready) begin
                exp_res = apply_request(req_data);
                owed_results.push_back(exp_res);
                op_count[int'(req_data.req_type)]++;
                if (exp_res.switched) switch_count++;
                if (exp_res.status == ST_EMPTY) empty_count++;
                v = 1'b0;
            end
            if (!v) begin
                if (send_gap > 0) begin
                    send_gap--;
                end else if (req_backlog.size() != 0) begin
                    if (!req_backlog[0].quiet && $urandom_range(0, 7) == 0) begin
                        // This cycle is the first idle one of the burst.
                        send_gap = $urandom_range(0, 4);
                    end else begin
                        nxt_item = req_backlog.pop_front();
                        req_data    <= nxt_item.rq;
                        quiet_phase <= nxt_item.quiet;
                        v = 1'b1;
                    end
                end
            end
        end
        req_valid <= v;
    end

    // Result monitor. Each result transfer is compared field by field with the oldest
    // owed result; the ready side stalls in random bursts until the quiet tail.
    always @(posedge i_clk) begin : check_results
        t_res want;
        logic r;
        r = res_ready;
        if (i_rst_n) begin
            if (res_valid && res_ready) begin
                if (owed_results.size() == 0) begin
                    mismatches++;
                    $error("result transfer with no request outstanding: %p", res_data);
                end else begin
                    want = owed_results.pop_front();
                    if (res_data.status !== want.status) begin
                        mismatches++;
                        $error("status: expected %0d, got %0d", want.status, res_data.status);
                    end
                    if (res_data.switched !== want.switched) begin
                        mismatches++;
                        $error("switched: expected %0d, got %0d",
                               want.switched, res_data.switched);
                    end
                    if (res_data.from_valid !== want.from_valid) begin
                        mismatches++;
                        $error("from_valid: expected %0d, got %0d",
                               want.from_valid, res_data.from_valid);
                    end
                    if (res_data.prev_thread !== want.prev_thread) begin
                        mismatches++;
                        $error("prev_thread: expected %0d, got %0d",
                               want.prev_thread, res_data.prev_thread);
                    end
                    if (res_data.next_thread !== want.next_thread) begin
                        mismatches++;
                        $error("next_thread: expected %0d, got %0d",
                               want.next_thread, res_data.next_thread);
                    end
                    if (res_data.to_priority !== want.to_priority) begin
                        mismatches++;
                        $error("to_priority: expected %0d, got %0d",
                               want.to_priority, res_data.to_priority);
                    end
                end
            end
            if (take_hold > 0) begin
                take_hold--;
                r = 1'b0;
            end else if (!quiet_phase && $urandom_range(0, 7) == 0) begin
                take_hold = $urandom_range(0, 4);
                r = 1'b0;
            end else begin
                r = 1'b1;
            end
        end
        res_ready <= r;
    end

    // Main sequence: reset, a directed walk through the special cases, a full drain,
    // then random traffic with periodic drains and queue flushes.
    initial begin : run_sequence
        int  pick;
        int  thr;
        int  pr;
        bit  quiet;

        ready_bits = '0;
        for (int i = 0; i < PRIORITY_LEVELS; i++) begin
            lvl_head[i] = '0;
            lvl_tail[i] = '0;
        end
        for (int i = 0; i < THREAD_SLOTS; i++) begin
            link_next[i]  = '0;
            link_prev[i]  = '0;
            is_queued[i]  = 1'b0;
            queued_lvl[i] = '0;
            gen_queued[i] = 1'b0;
        end
        run_thr   = '0;
        run_valid = 1'b0;
        run_lvl   = 5'(PRIORITY_LEVELS - 1);

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Scheduling with nothing ready, and a remove of a thread never queued.
        queue_request(REQ_SCHEDULE, 31, 31, 1'b0);
        queue_request(REQ_START, 0, 0, 1'b0);
        queue_request(REQ_REMOVE, 5, 0, 1'b0);
        // First thread at the most urgent level, then a double insert of it.
        queue_request(REQ_INSERT, 0, 0, 1'b0);
        queue_request(REQ_INSERT, 0, 3, 1'b0);
        // Schedule without a running thread counts as a switch; the repeat does not.
        queue_request(REQ_SCHEDULE, 21, 10, 1'b0);
        queue_request(REQ_SCHEDULE, 10, 21, 1'b0);
        queue_request(REQ_START, 31, 31, 1'b0);
        // Four threads on the least urgent level, with middle, head and tail removes.
        queue_request(REQ_INSERT, 31, 31, 1'b0);
        queue_request(REQ_INSERT, 7, 31, 1'b0);
        queue_request(REQ_INSERT, 12, 31, 1'b0);
        queue_request(REQ_INSERT, 20, 31, 1'b0);
        queue_request(REQ_REMOVE, 7, 0, 1'b0);
        // The running thread may be removed; it stays running until the next schedule.
        queue_request(REQ_REMOVE, 0, 0, 1'b0);
        queue_request(REQ_SCHEDULE, 0, 0, 1'b0);
        queue_request(REQ_REMOVE, 20, 0, 1'b0);
        queue_request(REQ_REMOVE, 31, 0, 1'b0);
        queue_request(REQ_START, 0, 0, 1'b0);
        queue_request(REQ_INSERT, 21, 21, 1'b0);
        queue_request(REQ_INSERT, 10, 10, 1'b0);
        queue_request(REQ_SCHEDULE, 0, 0, 1'b0);
        // Empty every level again; scheduling then finds nothing ready.
        queue_request(REQ_REMOVE, 12, 0, 1'b0);
        queue_request(REQ_REMOVE, 10, 0, 1'b0);
        queue_request(REQ_REMOVE, 21, 0, 1'b0);
        queue_request(REQ_START, 31, 31, 1'b0);
        settle();

        for (int n = 0; n < RAND_ITEMS; n++) begin
            quiet = (n >= RAND_ITEMS - QUIET_TAIL);
            if (n % 400 == 399 && !quiet) settle();
            if (n % 250 == 120) begin
                // Flush every queue, so that the bitmap empties now and then.
                for (int t = 0; t < THREAD_SLOTS; t++) begin
                    if (gen_queued[t]) queue_request(REQ_REMOVE, t, $urandom_range(0, 31), quiet);
                end
                queue_request(REQ_SCHEDULE, $urandom_range(0, 31), $urandom_range(0, 31), quiet);
            end
            pick = $urandom_range(0, 99);
            // Half the inserts crowd onto a few urgent levels to build long lists.
            pr = $urandom_range(0, 1) ? $urandom_range(0, 3) : $urandom_range(0, 31);
            if (pick < 32) begin
                thr = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 31) : pick_thread(1'b0);
                queue_request(REQ_INSERT, thr, pr, quiet);
            end else if (pick < 60) begin
                thr = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 31) : pick_thread(1'b1);
                queue_request(REQ_REMOVE, thr, pr, quiet);
            end else if (pick < 85) begin
                queue_request(REQ_SCHEDULE, $urandom_range(0, 31), pr, quiet);
            end else begin
                queue_request(REQ_START, $urandom_range(0, 31), pr, quiet);
            end
        end

        settle();
        repeat (8) @(negedge i_clk);
        if (owed_results.size() != 0) begin
            mismatches++;
            $error("%0d results never arrived", owed_results.size());
        end

        $display("Requests taken: %0d inserts, %0d removes, %0d schedules, %0d starts.",
                 op_count[0], op_count[1], op_count[2], op_count[3]);
        $display("They caused %0d thread switches and %0d answers with nothing ready.",
                 switch_count, empty_count);
        if (mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    // Watchdog: a correct run needs well under a tenth of this.
    initial begin : watchdog
        #5_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule

`default_nettype wire
